@@ rtl/upk_pkg.sv @@
// ----------------------------------------------------------------------------
// PCM unpacker package
// Shared types, register indexes and constants of the PCM byte stream unpacker.
// ----------------------------------------------------------------------------
package upk_pkg;

    localparam int DEF_MAX_CHANNELS = 16;
    // The channel port is four bits wide, so no more than 16 channels are counted.
    localparam int CHAN_LIMIT       = 16;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 8;

    localparam logic [31:0] SIGN_FLIP = 32'h8000_0000;

    localparam logic [2:0] RST_BYTES_PER_SAMPLE = 3'd2;
    localparam logic       RST_BIG_ENDIAN       = 1'b0;
    localparam logic       RST_IS_SIGNED        = 1'b1;
    localparam logic [4:0] RST_CHANNEL_COUNT    = 5'd1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_BYTES_PER_SAMPLE = 3'd0,
        REG_BIG_ENDIAN       = 3'd1,
        REG_IS_SIGNED        = 3'd2,
        REG_CHANNEL_COUNT    = 3'd3
    } t_reg_idx;

    typedef struct packed {
        logic [2:0] bytes_per_sample;
        logic       big_endian;
        logic       is_signed;
        logic [4:0] channel_count;
    } t_cfg;

    // One assembled sample on its way from the front to the output stage.
    typedef struct packed {
        logic [31:0] word;
        logic [3:0]  channel;
        logic        frame_last;
    } t_sample_rec;

endpackage

@@ rtl/upk_front.sv @@
// ----------------------------------------------------------------------------
// PCM unpacker front end
// Accepts bytes, gathers them into samples and tracks the channel of each one.
// ----------------------------------------------------------------------------
module upk_front #(
    parameter int MAX_CHANNELS = upk_pkg::DEF_MAX_CHANNELS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  upk_pkg::t_cfg        i_cfg,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_queue_full,
    output logic                 o_push,
    output upk_pkg::t_sample_rec o_push_data
);

    localparam int CAP  = (MAX_CHANNELS < upk_pkg::CHAN_LIMIT) ? MAX_CHANNELS
                                                               : upk_pkg::CHAN_LIMIT;
    localparam int CH_W = (CAP > 1) ? $clog2(CAP) : 1;
    localparam logic [4:0] CAP5 = 5'(CAP);

    logic [23:0]     r_partial;
    logic [23:0]     n_partial;
    logic [1:0]      r_byte_index;
    logic [1:0]      n_byte_index;
    logic [CH_W-1:0] r_ch_idx;
    logic [CH_W-1:0] n_ch_idx;

    logic [2:0]  n_eff;
    logic [4:0]  nch_eff;
    logic        accept;
    logic        completes;
    logic        last;
    logic [31:0] word;
    logic [31:0] part_ext;
    logic [7:0]  v;
    logic [2:0]  lane_sum;
    logic [1:0]  lane;

    assign o_ready = !i_queue_full;
    assign accept  = i_valid && o_ready;

    // Effective sample width and channel count after clamping to the legal range.
    always_comb begin
        if (i_cfg.bytes_per_sample == 3'd0) begin
            n_eff = 3'd1;
        end else if (i_cfg.bytes_per_sample > 3'd4) begin
            n_eff = 3'd4;
        end else begin
            n_eff = i_cfg.bytes_per_sample;
        end
        if (i_cfg.channel_count == 5'd0) begin
            nch_eff = 5'd1;
        end else if (i_cfg.channel_count > CAP5) begin
            nch_eff = CAP5;
        end else begin
            nch_eff = i_cfg.channel_count;
        end
    end

    assign completes = ({1'b0, r_byte_index} + 3'd1) >= n_eff;
    assign last      = (5'(r_ch_idx) + 5'd1) >= nch_eff;

    // Place each byte of the sample in its lane of the left-justified word.
    always_comb begin
        word     = 32'h0;
        part_ext = {8'h00, r_partial};
        v        = 8'h00;
        lane_sum = 3'd0;
        lane     = 2'd0;
        for (int k = 0; k < 4; k++) begin
            if (3'(k) < n_eff) begin
                if (3'(k) + 3'd1 == n_eff) begin
                    v = i_data_byte;
                end else begin
                    v = part_ext[8*k +: 8];
                end
                lane_sum = 3'(k) + 3'd4 - n_eff;
                lane     = i_cfg.big_endian ? 2'(3 - k) : lane_sum[1:0];
                word     = word | ({24'h0, v} << {lane, 3'b000});
            end
        end
    end

    always_comb begin
        n_partial    = r_partial;
        n_byte_index = r_byte_index;
        n_ch_idx     = r_ch_idx;
        if (accept) begin
            if (completes) begin
                n_partial    = 24'h0;
                n_byte_index = 2'd0;
                n_ch_idx     = last ? '0 : CH_W'(r_ch_idx + 1'b1);
            end else begin
                case (r_byte_index)
                    2'd0:    n_partial[7:0]   = i_data_byte;
                    2'd1:    n_partial[15:8]  = i_data_byte;
                    2'd2:    n_partial[23:16] = i_data_byte;
                    default: n_partial        = r_partial;
                endcase
                n_byte_index = r_byte_index + 2'd1;
            end
        end
    end

    assign o_push                 = accept && completes;
    assign o_push_data.word       = word;
    assign o_push_data.channel    = 4'(r_ch_idx);
    assign o_push_data.frame_last = last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_partial    <= 24'h0;
            r_byte_index <= 2'd0;
            r_ch_idx     <= '0;
        end else begin
            r_partial    <= n_partial;
            r_byte_index <= n_byte_index;
            r_ch_idx     <= n_ch_idx;
        end
    end

    // Held bytes only exist while a sample is partly assembled.
    a_partial_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_byte_index == 2'd0) |-> (r_partial == 24'h0))
        else $error("held bytes left over at the start of a sample");

    a_channel_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        5'(r_ch_idx) < CAP5)
        else $error("channel index beyond channel limit");

endmodule

@@ rtl/upk_queue.sv @@
// ----------------------------------------------------------------------------
// PCM unpacker sample queue
// Two-entry queue that lets the front end and the output stage stall apart.
// ----------------------------------------------------------------------------
module upk_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  upk_pkg::t_sample_rec i_push_data,
    output logic                 o_full,
    output logic                 o_valid,
    output upk_pkg::t_sample_rec o_data,
    input  logic                 i_pop
);

    upk_pkg::t_sample_rec r_entry [2];
    logic                 r_wr_ptr;
    logic                 n_wr_ptr;
    logic                 r_rd_ptr;
    logic                 n_rd_ptr;
    logic [1:0]           r_count;
    logic [1:0]           n_count;
    logic                 do_pop;

    assign o_full  = r_count == 2'd2;
    assign o_valid = r_count != 2'd0;
    assign o_data  = r_entry[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = !r_wr_ptr;
        end
        if (do_pop) begin
            n_rd_ptr = !r_rd_ptr;
        end
        if (i_push && !do_pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && do_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_push_data;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("push into full queue");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("queue count out of range");

endmodule

@@ rtl/upk_back.sv @@
// ----------------------------------------------------------------------------
// PCM unpacker output stage
// Converts queued samples to two's complement and holds them for the consumer.
// ----------------------------------------------------------------------------
module upk_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  upk_pkg::t_cfg        i_cfg,
    input  logic                 i_queue_valid,
    input  upk_pkg::t_sample_rec i_queue_data,
    output logic                 o_pop,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic signed [31:0]   o_sample,
    output logic [3:0]           o_channel,
    output logic                 o_frame_last
);

    logic        r_valid;
    logic        n_valid;
    logic [31:0] r_sample;
    logic [3:0]  r_channel;
    logic        r_frame_last;

    // The output register takes a new sample whenever it is empty or being drained.
    assign o_pop = i_queue_valid && (!r_valid || i_ready);

    always_comb begin
        n_valid = r_valid;
        if (o_pop) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Offset binary becomes two's complement by flipping the top bit.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_sample     <= i_cfg.is_signed ? i_queue_data.word
                                            : (i_queue_data.word ^ upk_pkg::SIGN_FLIP);
            r_channel    <= i_queue_data.channel;
            r_frame_last <= i_queue_data.frame_last;
        end
    end

    assign o_valid      = r_valid;
    assign o_sample     = r_sample;
    assign o_channel    = r_channel;
    assign o_frame_last = r_frame_last;

endmodule

@@ rtl/pcm_byte_stream_unpacker.sv @@
// ----------------------------------------------------------------------------
// PCM byte stream unpacker
// Turns an interleaved PCM byte stream into left-justified Q1.31 samples.
// ----------------------------------------------------------------------------
// One byte is taken per clock while the queue has room. Every bytes_per_sample
// bytes yield one sample on the output, left-justified in 32 bits, with its
// channel index and a flag on the last channel of each frame; unsigned formats
// are converted to two's complement. The byte assembler writes a sample into
// the two-entry queue at the edge that accepts its last byte, and the output
// register takes it from the queue once that register is empty or being
// drained. The input keeps taking bytes while a result waits, and stalls only
// once the queue is full. Registers are written through the configuration
// channel, which is always ready; write them only while no sample is pending.
module pcm_byte_stream_unpacker #(
    parameter int MAX_CHANNELS = upk_pkg::DEF_MAX_CHANNELS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [7:0]                         i_data_byte,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic signed [31:0]                 o_sample,
    output logic [3:0]                         o_channel,
    output logic                               o_frame_last,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [upk_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [upk_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    upk_pkg::t_cfg        r_cfg;
    upk_pkg::t_cfg        n_cfg;
    logic                 push;
    upk_pkg::t_sample_rec push_data;
    logic                 queue_full;
    logic                 queue_valid;
    upk_pkg::t_sample_rec queue_data;
    logic                 pop;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                upk_pkg::REG_BYTES_PER_SAMPLE: n_cfg.bytes_per_sample = i_cfg_data[2:0];
                upk_pkg::REG_BIG_ENDIAN:       n_cfg.big_endian       = i_cfg_data[0];
                upk_pkg::REG_IS_SIGNED:        n_cfg.is_signed        = i_cfg_data[0];
                upk_pkg::REG_CHANNEL_COUNT:    n_cfg.channel_count    = i_cfg_data[4:0];
                default:                       n_cfg                  = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bytes_per_sample <= upk_pkg::RST_BYTES_PER_SAMPLE;
            r_cfg.big_endian       <= upk_pkg::RST_BIG_ENDIAN;
            r_cfg.is_signed        <= upk_pkg::RST_IS_SIGNED;
            r_cfg.channel_count    <= upk_pkg::RST_CHANNEL_COUNT;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    upk_front #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_data_byte  (i_data_byte),
        .i_queue_full (queue_full),
        .o_push       (push),
        .o_push_data  (push_data)
    );

    upk_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .o_full      (queue_full),
        .o_valid     (queue_valid),
        .o_data      (queue_data),
        .i_pop       (pop)
    );

    upk_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_queue_valid (queue_valid),
        .i_queue_data  (queue_data),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_sample      (o_sample),
        .o_channel     (o_channel),
        .o_frame_last  (o_frame_last)
    );

endmodule

@@ dv/upk_checker.sv @@
// ----------------------------------------------------------------------------
// PCM unpacker checker
// Watches the byte, sample and register channels of the PCM byte stream
// unpacker, rebuilds every sample from the accepted bytes and compares it
// with what the block hands out.
// ----------------------------------------------------------------------------
module upk_checker #(
    parameter int MAX_CHANNELS = upk_pkg::DEF_MAX_CHANNELS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_ready,
    input  logic [7:0]                      i_in_byte,
    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    input  logic signed [31:0]              i_out_sample,
    input  logic [3:0]                      i_out_channel,
    input  logic                            i_out_frame_last,
    input  logic                            i_cfg_valid,
    input  logic                            i_cfg_ready,
    input  logic [upk_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [upk_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output int                              o_fail_count,
    output int                              o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // Register copies.
    logic [2:0]  width_reg;
    logic        big_endian_reg;
    logic        signed_reg;
    logic [4:0]  chan_count_reg;

    // Assembly state.
    logic [23:0] held_bytes;
    logic [1:0]  held_count;
    logic [3:0]  cur_channel;

    upk_pkg::t_sample_rec pending_samples[$];

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t ns: %s mismatch, got %h, expected %h", $time, what, got, want);
        o_fail_count++;
    endtask

    // Takes one accepted byte; queues a sample when the byte completes one.
    task automatic assemble_byte(input logic [7:0] b);
        int unsigned n;
        int unsigned nch;
        int unsigned cap;
        int unsigned sh;
        logic [7:0]  v;
        logic [31:0] word;
        logic        last;
        upk_pkg::t_sample_rec rec;
        n = (width_reg < 3'd1) ? 1 : (width_reg > 3'd4) ? 4 : int'(width_reg);
        if (held_count + 1 < n) begin
            held_bytes[8*held_count +: 8] = b;
            held_count = held_count + 2'd1;
        end else begin
            word = '0;
            for (int unsigned k = 0; k < n; k++) begin
                if (k + 1 == n)
                    v = b;
                else
                    v = held_bytes[8*k +: 8];
                sh = big_endian_reg ? 8 * (3 - k) : 8 * (4 - n + k);
                word |= {24'b0, v} << sh;
            end
            if (!signed_reg)
                word ^= upk_pkg::SIGN_FLIP;
            cap = (MAX_CHANNELS < upk_pkg::CHAN_LIMIT) ? MAX_CHANNELS
                                                       : upk_pkg::CHAN_LIMIT;
            if (cap < 1)
                cap = 1;
            if (chan_count_reg < 5'd1)
                nch = 1;
            else if (chan_count_reg > cap)
                nch = cap;
            else
                nch = chan_count_reg;
            last = (cur_channel + 1 >= nch);
            rec.word = word;
            rec.channel = cur_channel;
            rec.frame_last = last;
            pending_samples.push_back(rec);
            cur_channel = last ? 4'd0 : cur_channel + 4'd1;
            held_count = 2'd0;
            held_bytes = '0;
        end
    endtask

    always @(posedge i_clk) begin
        upk_pkg::t_sample_rec want;
        if (!i_rst_n) begin
            width_reg = upk_pkg::RST_BYTES_PER_SAMPLE;
            big_endian_reg = upk_pkg::RST_BIG_ENDIAN;
            signed_reg = upk_pkg::RST_IS_SIGNED;
            chan_count_reg = upk_pkg::RST_CHANNEL_COUNT;
            held_bytes = '0;
            held_count = '0;
            cur_channel = '0;
            pending_samples.delete();
            o_fail_count = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (pending_samples.size() == 0) begin
                    report_mismatch("unexpected sample", i_out_sample, '0);
                end else begin
                    want = pending_samples.pop_front();
                    if (i_out_sample !== want.word)
                        report_mismatch("sample", i_out_sample, want.word);
                    if (i_out_channel !== want.channel)
                        report_mismatch("channel", {28'b0, i_out_channel},
                                        {28'b0, want.channel});
                    if (i_out_frame_last !== want.frame_last)
                        report_mismatch("frame_last", {31'b0, i_out_frame_last},
                                        {31'b0, want.frame_last});
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    upk_pkg::REG_BYTES_PER_SAMPLE: width_reg = i_cfg_data[2:0];
                    upk_pkg::REG_BIG_ENDIAN:       big_endian_reg = i_cfg_data[0];
                    upk_pkg::REG_IS_SIGNED:        signed_reg = i_cfg_data[0];
                    upk_pkg::REG_CHANNEL_COUNT:    chan_count_reg = i_cfg_data[4:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready)
                assemble_byte(i_in_byte);
        end
        o_pending = pending_samples.size();
    end

endmodule

@@ dv/tb_pcm_byte_stream_unpacker.sv @@
// ----------------------------------------------------------------------------
// PCM byte stream unpacker testbench
// Drives bytes and register writes into the unpacker with random gaps and
// output stalls; a checker beside the block predicts and compares samples.
// ----------------------------------------------------------------------------
module tb_pcm_byte_stream_unpacker;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int TARGET_BYTES = 1725;
    localparam int SETTLE_CYCLES = 4;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_valid;
    logic                            o_ready;
    logic [7:0]                      i_data_byte;
    logic                            o_valid;
    logic                            i_ready;
    logic signed [31:0]              o_sample;
    logic [3:0]                      o_channel;
    logic                            o_frame_last;
    logic                            i_cfg_valid;
    logic                            o_cfg_ready;
    logic [upk_pkg::CFG_INDEX_W-1:0] i_cfg_index;
    logic [upk_pkg::CFG_DATA_W-1:0]  i_cfg_data;

    int fail_count;
    int pending;
    int cycles;
    int bytes_sent;
    bit rx_hold_req;

    pcm_byte_stream_unpacker dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_data_byte  (i_data_byte),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_sample     (o_sample),
        .o_channel    (o_channel),
        .o_frame_last (o_frame_last),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    upk_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_valid),
        .i_in_ready       (o_ready),
        .i_in_byte        (i_data_byte),
        .i_out_valid      (o_valid),
        .i_out_ready      (i_ready),
        .i_out_sample     (o_sample),
        .i_out_channel    (o_channel),
        .i_out_frame_last (o_frame_last),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("FAIL");
        $finish;
    end

    // Sample receiver: random ready pattern, plus a long hold-off on request.
    // A request cuts the current stretch short so the hold-off starts at once.
    initial begin
        int unsigned pick;
        int unsigned len;
        logic        level;
        i_ready = 1'b0;
        forever begin
            pick = $urandom_range(0, 99);
            if (rx_hold_req) begin
                level = 1'b0;
                len = 300;
                rx_hold_req = 1'b0;
            end else if (pick < 50) begin
                level = 1'b1;
                len = $urandom_range(1, 30);
            end else if (pick < 90) begin
                level = 1'b0;
                len = $urandom_range(1, 3);
            end else if (pick < 98) begin
                level = 1'b0;
                len = $urandom_range(4, 20);
            end else begin
                level = 1'b0;
                len = $urandom_range(30, 120);
            end
            repeat (len) begin
                if (rx_hold_req)
                    break;
                @(negedge i_clk);
                i_ready <= level;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_data_byte <= b;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        bytes_sent++;
    endtask

    task automatic sender_pause();
        int unsigned pick;
        int unsigned len;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            len = 0;
        else if (pick < 90)
            len = $urandom_range(1, 3);
        else if (pick < 98)
            len = $urandom_range(4, 12);
        else
            len = $urandom_range(20, 40);
        repeat (len) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
    endtask

    task automatic cfg_write(input logic [upk_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [upk_pkg::CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Stops offering bytes and waits until every predicted sample is out.
    task automatic drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    initial begin
        int unsigned phase_len;
        int unsigned fld;
        bit          no_gaps;
        bit          first_phase;
        logic [7:0]  b;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data_byte = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        rx_hold_req = 1'b0;
        bytes_sent = 0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset format: 16-bit little-endian signed mono.
        send_byte(8'h00);
        send_byte(8'h80);
        send_byte(8'hFF);
        send_byte(8'h7F);
        drain();

        // 8-bit unsigned: the top bit is flipped.
        cfg_write(upk_pkg::REG_BYTES_PER_SAMPLE, 8'd1);
        cfg_write(upk_pkg::REG_IS_SIGNED, 8'd0);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h80);
        drain();

        // 32-bit big-endian signed, three channels.
        cfg_write(upk_pkg::REG_BYTES_PER_SAMPLE, 8'd4);
        cfg_write(upk_pkg::REG_BIG_ENDIAN, 8'd1);
        cfg_write(upk_pkg::REG_IS_SIGNED, 8'd1);
        cfg_write(upk_pkg::REG_CHANNEL_COUNT, 8'd3);
        send_byte(8'h12);
        send_byte(8'h34);
        send_byte(8'h56);
        send_byte(8'h78);
        send_byte(8'hFF);
        send_byte(8'hFF);
        send_byte(8'hFF);
        send_byte(8'hFF);
        send_byte(8'hA5);
        send_byte(8'h5A);
        send_byte(8'hC3);
        drain();

        // Narrowing the sample and the frame while both are partly filled.
        cfg_write(upk_pkg::REG_BYTES_PER_SAMPLE, 8'd2);
        cfg_write(upk_pkg::REG_CHANNEL_COUNT, 8'd2);
        send_byte(8'h3C);
        drain();

        // Out-of-range widths and channel counts, and an unused index.
        cfg_write(upk_pkg::REG_BYTES_PER_SAMPLE, 8'h08);
        cfg_write(upk_pkg::REG_CHANNEL_COUNT, 8'h00);
        cfg_write(upk_pkg::REG_BIG_ENDIAN, 8'hFE);
        send_byte(8'h01);
        send_byte(8'hFE);
        drain();
        cfg_write(upk_pkg::REG_BYTES_PER_SAMPLE, 8'hFF);
        cfg_write(upk_pkg::REG_CHANNEL_COUNT, 8'hFF);
        cfg_write(upk_pkg::REG_CHANNEL_COUNT + 3'd4, 8'hFF);
        send_byte(8'h80);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'h7F);
        drain();
        cfg_write(upk_pkg::REG_CHANNEL_COUNT, 8'd17);
        cfg_write(upk_pkg::REG_IS_SIGNED, 8'hFE);
        drain();

        first_phase = 1'b1;
        while (bytes_sent < TARGET_BYTES) begin
            repeat ($urandom_range(1, 4)) begin
                case ($urandom_range(0, 4))
                    0: begin
                        if ($urandom_range(0, 9) == 0)
                            fld = $urandom_range(0, 1) ? 0 : $urandom_range(5, 7);
                        else
                            fld = $urandom_range(1, 4);
                        cfg_write(upk_pkg::REG_BYTES_PER_SAMPLE, {5'($urandom), 3'(fld)});
                    end
                    1: cfg_write(upk_pkg::REG_BIG_ENDIAN, 8'($urandom));
                    2: cfg_write(upk_pkg::REG_IS_SIGNED, 8'($urandom));
                    3: begin
                        if ($urandom_range(0, 7) == 0)
                            fld = $urandom_range(0, 1) ? 0 : $urandom_range(17, 31);
                        else
                            fld = $urandom_range(1, 16);
                        cfg_write(upk_pkg::REG_CHANNEL_COUNT, {3'($urandom), 5'(fld)});
                    end
                    default: cfg_write(upk_pkg::REG_CHANNEL_COUNT
                                           + 3'($urandom_range(1, 4)),
                                       8'($urandom));
                endcase
            end

            phase_len = $urandom_range(5, 80);
            no_gaps = ($urandom_range(0, 3) == 0);
            // The first phase runs into a long receiver hold-off so the
            // block fills up and pushes back on the byte channel.
            if (first_phase) begin
                rx_hold_req = 1'b1;
                phase_len = 64;
                no_gaps = 1'b1;
                first_phase = 1'b0;
            end
            repeat (phase_len) begin
                if ($urandom_range(0, 9) == 0) begin
                    case ($urandom_range(0, 3))
                        0: b = 8'h00;
                        1: b = 8'hFF;
                        2: b = 8'h80;
                        default: b = 8'h7F;
                    endcase
                end else begin
                    b = 8'($urandom_range(0, 255));
                end
                send_byte(b);
                if (!no_gaps)
                    sender_pause();
            end
            drain();
        end

        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
